### sv/dfr_pkg.sv
// Package for the delimited frame receiver: frame size, control characters,
// and the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package dfr_pkg;

  // Bytes in one emitted frame, the closing newline included.
  localparam int unsigned PACKET_BYTES = 14;
  // Data bytes held before the newline.
  localparam int unsigned HOLD_MAX = PACKET_BYTES - 1;
  // Fill count and read pointer width: holds 0 .. HOLD_MAX.
  localparam int unsigned CNT_W = $clog2(HOLD_MAX + 1);
  // Store address width.
  localparam int unsigned ADDR_W = (HOLD_MAX > 1) ? $clog2(HOLD_MAX) : 1;

  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_TAB = 8'h09;

  typedef struct packed {
    logic take;   // an input beat is accepted this cycle
    logic load;   // load the output register with the next frame byte
    logic drop;   // the last frame byte was taken, clear output valid
  } dfr_cmd_t;

  typedef struct packed {
    logic frame_ready;  // current input byte closes a full frame
    logic last;         // output register holds the closing newline
  } dfr_sts_t;

endpackage

`default_nettype wire

### sv/dfr_datapath.sv
// Datapath of the delimited frame receiver: arming flag, fill count, frame
// store, read pointer and output register. Depends on dfr_pkg.
`default_nettype none

module dfr_datapath (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [7:0]      in_byte_in,
  input  wire dfr_pkg::dfr_cmd_t cmd,
  output dfr_pkg::dfr_sts_t    sts,
  output logic                 out_valid,
  output logic [7:0]           out_byte,
  output logic                 out_frame_end
);

  logic [7:0]               store_mem [dfr_pkg::HOLD_MAX];
  logic                     armed_r, armed_nxt;
  logic [dfr_pkg::CNT_W-1:0] fill_r, fill_nxt;
  logic [dfr_pkg::CNT_W-1:0] ptr_r, ptr_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [7:0]               out_byte_r;
  logic                     out_end_r;
  logic                     is_nl, is_cr, is_tab;
  logic                     store_en, full;

  always_comb begin
    is_nl    = (in_byte_in == dfr_pkg::CH_NL);
    is_cr    = (in_byte_in == dfr_pkg::CH_CR);
    is_tab   = (in_byte_in == dfr_pkg::CH_TAB);
    full     = (fill_r == dfr_pkg::CNT_W'(dfr_pkg::HOLD_MAX));
    store_en = cmd.take && armed_r && !is_nl && !is_cr && !is_tab && !full;

    armed_nxt = armed_r;
    fill_nxt  = fill_r;
    ptr_nxt   = ptr_r;
    if (cmd.take) begin
      if (!armed_r) begin
        armed_nxt = is_tab;
      end else if (is_nl) begin
        armed_nxt = 1'b0;
        fill_nxt  = '0;
        ptr_nxt   = '0;
      end else if (store_en) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
    if (cmd.load) begin
      ptr_nxt = ptr_r + 1'b1;
    end

    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (cmd.drop) begin
      out_valid_nxt = 1'b0;
    end

    sts.frame_ready = armed_r && is_nl && full;
    sts.last        = out_end_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r     <= 1'b0;
      fill_r      <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      armed_r     <= armed_nxt;
      fill_r      <= fill_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Store write port and registered read into the output register.
  always_ff @(posedge clk) begin
    if (store_en) begin
      store_mem[fill_r[dfr_pkg::ADDR_W-1:0]] <= in_byte_in;
    end
    if (cmd.load) begin
      if (ptr_r == dfr_pkg::CNT_W'(dfr_pkg::HOLD_MAX)) begin
        out_byte_r <= dfr_pkg::CH_NL;
        out_end_r  <= 1'b1;
      end else begin
        out_byte_r <= store_mem[ptr_r[dfr_pkg::ADDR_W-1:0]];
        out_end_r  <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_frame_end = out_end_r;

endmodule

`default_nettype wire

### sv/dfr_ctrl.sv
// Controller of the delimited frame receiver: a three-state machine that
// takes input beats and sequences the frame drain. Depends on dfr_pkg.
`default_nettype none

module dfr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              out_stall,
  input  wire dfr_pkg::dfr_sts_t sts,
  output dfr_pkg::dfr_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_SHOW = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
        if (in_valid && sts.frame_ready) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        if (!out_stall) begin
          if (sts.last) begin
            cmd.drop  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/delimited_frame_receiver.sv
// Top level of the delimited frame receiver: joins controller and datapath
// and carries the checks. Depends on dfr_pkg, dfr_ctrl and dfr_datapath.
//
//   Channel   Handshake              Per beat
//   -------   --------------------   -------------------------------------
//   in_       in_valid / in_stall    in_byte_in: one received byte
//   out_      out_valid / out_stall  out_byte, out_frame_end (newline last)
//
// While no frame drains, one input beat is taken every cycle. A newline that
// closes a frame of PACKET_BYTES-1 held data bytes stalls the input while the
// output register is loaded from the frame store and while the frame drains,
// PACKET_BYTES beats with the newline last, also while out_stall holds a beat.
// The frame store has a single read port.
// Reset (synchronous, active low) clears arming flag, fill count, read pointer, output valid.
`default_nettype none

module delimited_frame_receiver (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_frame_end
);

  dfr_pkg::dfr_cmd_t cmd;
  dfr_pkg::dfr_sts_t sts;

  dfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dfr_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_byte_in    (in_byte_in),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end)
  );

  // No input beat is taken while a frame byte waits at the output.
  a_no_input_while_draining: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken during a frame drain");

  // The closing beat of a frame is always the newline.
  a_end_is_newline: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> (out_byte == dfr_pkg::CH_NL))
    else $error("frame end beat is not a newline");

  // Once the closing beat is taken, the output goes quiet.
  a_quiet_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_frame_end) |=> !out_valid)
    else $error("output still valid after frame end");

  // A newline that closes a full frame starts the drain after the load state.
  a_drain_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && sts.frame_ready) |=> ##1 (out_valid && !out_frame_end))
    else $error("full frame did not start draining");

endmodule

`default_nettype wire

### dv/dfr_frame_checker.sv
`timescale 1ns / 1ps
// Frame checker for the delimited frame receiver: watches both channels,
// predicts the emitted frame bytes and compares them. Depends on dfr_pkg.
module dfr_frame_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [7:0] in_byte_in,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [7:0] out_byte,
  input  wire logic       out_frame_end,
  output int              mismatch_count,
  output int              beats_pending
);

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  // Receiver state as the block should hold it.
  logic                      rx_armed;
  logic [dfr_pkg::CNT_W-1:0] rx_fill;
  logic [7:0]                rx_hold [dfr_pkg::HOLD_MAX];

  frame_beat_t frame_due [$];
  int          errors = 0;

  // Applies one received byte and queues any frame bytes it releases.
  task automatic absorb_byte(input logic [7:0] b);
    frame_beat_t beat;
    if (!rx_armed) begin
      if (b == dfr_pkg::CH_TAB) rx_armed = 1'b1;
    end else if (b == dfr_pkg::CH_NL) begin
      if (rx_fill == dfr_pkg::HOLD_MAX) begin
        for (int i = 0; i < dfr_pkg::HOLD_MAX; i++) begin
          beat.data = rx_hold[i];
          beat.last = 1'b0;
          frame_due.push_back(beat);
        end
        beat.data = dfr_pkg::CH_NL;
        beat.last = 1'b1;
        frame_due.push_back(beat);
      end
      rx_fill  = '0;
      rx_armed = 1'b0;
    end else if (b != dfr_pkg::CH_CR && b != dfr_pkg::CH_TAB &&
                 rx_fill < dfr_pkg::HOLD_MAX) begin
      rx_hold[rx_fill] = b;
      rx_fill          = rx_fill + 1'b1;
    end
  endtask

  task automatic check_beat(input logic [7:0] data, input logic last);
    frame_beat_t want;
    if (frame_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected beat, expected none, got byte %02h frame_end %0b",
               $time, data, last);
    end else begin
      want = frame_due.pop_front();
      if (data !== want.data) begin
        errors++;
        $display("%0t: out_byte expected %02h, got %02h", $time, want.data, data);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: out_frame_end expected %0b, got %0b", $time, want.last, last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rx_armed = 1'b0;
      rx_fill  = '0;
      frame_due.delete();
    end else begin
      if (out_valid && !out_stall) check_beat(out_byte, out_frame_end);
      if (in_valid && !in_stall) absorb_byte(in_byte_in);
    end
    mismatch_count <= errors;
    beats_pending  <= frame_due.size();
  end

endmodule

### dv/tb_delimited_frame_receiver.sv
`timescale 1ns / 1ps
// Testbench top for the delimited frame receiver: clock, reset, byte stimulus,
// sink stalls and the verdict. Depends on dfr_pkg, the block and dfr_frame_checker.
module tb_delimited_frame_receiver;

  // Generous bound on the whole run, in clock cycles.
  localparam int RUN_LIMIT = 200000;
  // Input beats after which the random part stops.
  localparam int ITEM_TARGET = 480;
  // Length of the long sink hold-off, in cycles.
  localparam int HOLD_CYCLES = 250;
  // Cycles allowed after the last expected beat for stray output.
  localparam int DRAIN_TAIL = 40;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte_in = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_frame_end;

  int mismatch_count;
  int beats_pending;

  // Both sides stop idling while this is set.
  logic quiet = 1'b0;
  // Set by the stimulus to start one long sink hold-off.
  logic hold_req = 1'b0;
  // Set by the sink once that hold-off has started.
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   cycle_count = 0;
  // Input beats sent so far.
  int   item_count = 0;

  delimited_frame_receiver i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte_in   (in_byte_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_frame_end(out_frame_end)
  );

  dfr_frame_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte_in    (in_byte_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end),
    .mismatch_count(mismatch_count),
    .beats_pending (beats_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog. A correct run finishes far below this bound, so reaching it
  // means the block has hung or lost beats.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Sink side. It normally stalls at random, with a chance of about one in seven. A
  // hold-off request makes it stall for a long, counted stretch so that a
  // draining frame backs up and the block holds its input stalled.
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 14);
    end
  end

  // Offers one byte and returns at the edge where the beat is taken. The
  // payload stays put while the block stalls. An idle gap, when one is drawn,
  // comes before the beat, so a beat that follows right after the previous
  // one keeps in_valid high without dropping it.
  task automatic send_beat(input logic [7:0] b);
    if (!quiet && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 20);
    end
    in_valid   <= 1'b1;
    in_byte_in <= b;
    do @(posedge clk); while (!(in_valid && !in_stall));
    item_count++;
  endtask

  // A data byte that the block stores: anything but the three control characters.
  function automatic logic [7:0] pick_data();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == dfr_pkg::CH_NL || b == dfr_pkg::CH_CR || b == dfr_pkg::CH_TAB);
    return b;
  endfunction

  // Sends one frame: up to three idle bytes before the arming tab, then n_data data
  // bytes with the odd carriage return or tab mixed in, then the newline.
  // With n_data equal to HOLD_MAX the frame is emitted; fewer discards it and
  // more overruns the store, the extra bytes being dropped.
  task automatic send_frame(input int n_data);
    logic [7:0] b;
    int         n_noise;
    n_noise = ($urandom_range(99) < 30) ? $urandom_range(1, 3) : 0;
    repeat (n_noise) begin
      // While disarmed any byte but a tab is ignored, newlines included.
      do b = 8'($urandom_range(255)); while (b == dfr_pkg::CH_TAB);
      send_beat(b);
    end
    send_beat(dfr_pkg::CH_TAB);
    for (int i = 0; i < n_data; i++) begin
      if ($urandom_range(99) < 5) begin
        send_beat($urandom_range(1) ? dfr_pkg::CH_CR : dfr_pkg::CH_TAB);
      end
      send_beat(pick_data());
    end
    send_beat(dfr_pkg::CH_NL);
  endtask

  // Stops sending until every expected beat has left the block.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (beats_pending != 0);
  endtask

  initial begin
    int frame_no;
    int pick;
    int n_data;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Idle traffic while disarmed, a newline among it, must
    // be ignored.
    send_beat(8'h00);
    send_beat(8'hFF);
    send_beat(dfr_pkg::CH_NL);
    send_beat(dfr_pkg::CH_CR);
    // Arm, then a second tab that is ignored while armed. The frame carries
    // both byte extremes and a walking one, with a carriage return inside.
    send_beat(dfr_pkg::CH_TAB);
    send_beat(dfr_pkg::CH_TAB);
    send_beat(8'h00);
    send_beat(dfr_pkg::CH_CR);
    send_beat(8'hFF);
    send_beat(8'h01);
    send_beat(8'h02);
    send_beat(8'h04);
    send_beat(8'h08);
    send_beat(8'h10);
    send_beat(8'h20);
    send_beat(8'h40);
    send_beat(8'h80);
    send_beat(8'h7F);
    send_beat(8'hFE);
    send_beat(8'h55);
    send_beat(dfr_pkg::CH_NL);
    // A short frame is discarded without output.
    send_beat(dfr_pkg::CH_TAB);
    send_beat(8'h41);
    send_beat(dfr_pkg::CH_NL);

    // Random part: mostly full frames with random content, some overlong
    // and some short ones.
    frame_no = 0;
    while (item_count < ITEM_TARGET) begin
      if (frame_no == 4) hold_req = 1'b1;
      quiet = (frame_no >= 8 && frame_no < 14);
      if (frame_no == 18) wait_drained();
      pick = $urandom_range(99);
      if (pick < 70) n_data = dfr_pkg::HOLD_MAX;
      else if (pick < 82) n_data = dfr_pkg::HOLD_MAX + $urandom_range(1, 4);
      else n_data = $urandom_range(dfr_pkg::HOLD_MAX - 1);
      send_frame(n_data);
      frame_no++;
    end

    quiet = 1'b0;
    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
